/* rtl/core/bda_pkg.sv */
package bda_pkg;

  // operand and digit geometry
  localparam int VALUE_W   = 64;
  localparam int HALF_W    = 32;
  localparam int BUF_W     = 8;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int NUM_CELLS = 20;
  localparam int STEP_BITS = 8;
  localparam int STEPS     = VALUE_W / STEP_BITS;
  localparam int CNT_W     = $clog2(STEPS);
  localparam int PTR_W     = $clog2(NUM_CELLS);
  localparam int LEN_W     = $clog2(NUM_CELLS + 3);

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_CHECK,
    S_ERR,
    S_SIGN,
    S_DIGIT,
    S_TERM
  } state_t;

  // control from the sequencer to the digit chain
  typedef struct packed {
    logic load;
    logic step;
  } conv_ctrl_t;

  // add-three correction ahead of each shift
  function automatic logic [DIGIT_W-1:0] dd_adjust(input logic [DIGIT_W-1:0] d);
    dd_adjust = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

/* rtl/core/binary_to_decimal_ascii.sv */
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   value, signed_mode, buffer_size
// out      output     out_valid / out_stall character, overflow_error, last
//
// an item is loaded, passes through the digit chain at 8 bits per cycle, then has
// its digits counted and its buffer checked, then gives out its results (1 to 21
// of them) at one result per cycle while out is not stalled.
// rst is synchronous and clears the sequencer and the output valid.
// a stall on out holds the current result and pauses emission; in_stall is high
// from acceptance until the last result has been written to the output register.
module binary_to_decimal_ascii import bda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               signed_mode,
  input  logic [BUF_W-1:0]   buffer_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  character,
  output logic               overflow_error,
  output logic               last
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [PTR_W-1:0]   ptr, ptr_next;
  logic               neg;
  logic [BUF_W-1:0]   buf_size;
  conv_ctrl_t         ctrl;
  logic [VALUE_W-1:0] mag_in;
  logic [HALF_W-1:0]  low;
  logic [DIGIT_W-1:0] digits [NUM_CELLS];
  logic [PTR_W-1:0]   hi_idx;
  logic [LEN_W-1:0]   need_len;
  logic               ovf;
  logic               out_free;
  logic               emit;
  logic [CHAR_W-1:0]  emit_char;
  logic               emit_err;
  logic               emit_last;

  // magnitude of the incoming value
  assign low    = value[HALF_W-1:0];
  assign mag_in = signed_mode
                ? {{(VALUE_W-HALF_W){1'b0}}, (low[HALF_W-1] ? ({HALF_W{1'b0}} - low) : low)}
                : value;

  bda_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .mag_in (mag_in),
    .digits (digits)
  );

  // highest non-zero digit, zero value keeps one digit
  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (digits[i] != '0) begin
        hi_idx = PTR_W'(i);
      end
    end
  end

  // sign + digits + terminator against the buffer
  assign need_len = LEN_W'(hi_idx) + LEN_W'(2) + LEN_W'(neg);
  assign ovf      = BUF_W'(need_len) > buf_size;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ptr_next   = ptr;
    ctrl       = '0;
    emit       = 1'b0;
    emit_char  = CHAR_NUL;
    emit_err   = 1'b0;
    emit_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load  = 1'b1;
          cnt_next   = '0;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.step = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        ptr_next = hi_idx;
        if (ovf) begin
          state_next = S_ERR;
        end else if (neg) begin
          state_next = S_SIGN;
        end else begin
          state_next = S_DIGIT;
        end
      end
      S_ERR: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_err   = 1'b1;
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_char  = CHAR_MINUS;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CHAR_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, digits[ptr]};
          if (ptr == '0) begin
            state_next = S_TERM;
          end else begin
            ptr_next = ptr - 1'b1;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ptr   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ptr   <= ptr_next;
    end
  end

  // item fields kept for the check
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg      <= signed_mode && low[HALF_W-1];
      buf_size <= buffer_size;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character      <= emit_char;
      overflow_error <= emit_err;
      last           <= emit_last;
    end
  end

  // an accepted transfer always starts the conversion
  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_CONV)
    else $error("accepted item did not enter conversion");

  // the check follows a full conversion
  a_check_after_conv: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(state) == S_CONV && $past(cnt) == CNT_W'(STEPS - 1))
    else $error("digit check reached before conversion finished");

  // digit pointer stays on the chain
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIGIT |-> ptr < PTR_W'(NUM_CELLS))
    else $error("digit pointer beyond last cell");

  // an error result is a lone zero byte marked last
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_error |-> last && character == CHAR_NUL)
    else $error("malformed error result");

endmodule

/* rtl/core/bda_cell.sv */
module bda_cell import bda_pkg::*; (
  input  logic                 clk,
  input  conv_ctrl_t           ctrl,
  input  logic [STEP_BITS-1:0] bits_in,
  output logic [STEP_BITS-1:0] bits_out,
  output logic [DIGIT_W-1:0]   digit
);

  logic [DIGIT_W-1:0] digit_next;

  // several dabble steps per cycle, msb of the chunk first
  always_comb begin
    logic [DIGIT_W-1:0] d;
    logic [DIGIT_W-1:0] c;
    d = digit;
    c = '0;
    bits_out = '0;
    for (int k = STEP_BITS - 1; k >= 0; k--) begin
      c = dd_adjust(d);
      bits_out[k] = c[DIGIT_W-1];
      d = {c[DIGIT_W-2:0], bits_in[k]};
    end
    digit_next = d;
  end

  // digit register
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      digit <= '0;
    end else if (ctrl.step) begin
      digit <= digit_next;
    end
  end

endmodule

/* rtl/core/bda_conv.sv */
module bda_conv import bda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  conv_ctrl_t         ctrl,
  input  logic [VALUE_W-1:0] mag_in,
  output logic [DIGIT_W-1:0] digits [NUM_CELLS]
);

  logic [VALUE_W-1:0]   mag;
  logic [STEP_BITS-1:0] link [NUM_CELLS+1];

  // magnitude feeds the chain one chunk per cycle
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= mag_in;
    end else if (ctrl.step) begin
      mag <= mag << STEP_BITS;
    end
  end

  assign link[0] = mag[VALUE_W-1 -: STEP_BITS];

  // row of bcd digit cells, least significant first
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    bda_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bits_in  (link[i]),
      .bits_out (link[i+1]),
      .digit    (digits[i])
    );
  end

  // twenty digits always hold a 64-bit value
  a_no_spill: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |-> link[NUM_CELLS] == '0)
    else $error("digit chain spilled past the top cell");

endmodule

/* sim/decimal_text_checker.sv */
`timescale 1ns / 1ps

module decimal_text_checker import bda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               signed_mode,
  input  logic [BUF_W-1:0]   buffer_size,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CHAR_W-1:0]  character,
  input  logic               overflow_error,
  input  logic               last,
  output int                 fail_count,
  output int                 pending
);

  localparam int RADIX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              err;
    logic              end_mark;
  } text_byte_t;

  // bytes still owed by the block, oldest first
  text_byte_t expected_text[$];
  text_byte_t want;
  text_byte_t got;

  // expand one number into the bytes it should produce
  task automatic predict_text(input logic [VALUE_W-1:0] num, input logic sm,
                              input logic [BUF_W-1:0] room);
    logic [VALUE_W-1:0] mag;
    logic [HALF_W-1:0]  low;
    logic [HALF_W-1:0]  low_mag;
    logic               neg;
    logic [DIGIT_W-1:0] digs [NUM_CELLS];
    int                 nd;
    neg = 1'b0;
    nd  = 0;
    // signed mode reads only the low half, magnitude kept as 32-bit unsigned
    if (sm) begin
      low     = num[HALF_W-1:0];
      neg     = low[HALF_W-1];
      low_mag = neg ? (~low + 1'b1) : low;
      mag     = {{(VALUE_W-HALF_W){1'b0}}, low_mag};
    end else begin
      mag = num;
    end
    // digits, least significant first
    do begin
      digs[nd] = DIGIT_W'(mag % RADIX);
      mag      = mag / RADIX;
      nd++;
    end while (mag != 0 && nd < NUM_CELLS);
    // sign, digits and terminator must all fit
    if (int'(neg) + nd + 1 > int'(room)) begin
      expected_text.push_back('{code: CHAR_NUL, err: 1'b1, end_mark: 1'b1});
    end else begin
      if (neg) expected_text.push_back('{code: CHAR_MINUS, err: 1'b0, end_mark: 1'b0});
      for (int i = nd - 1; i >= 0; i--) begin
        expected_text.push_back('{code: CHAR_ZERO + CHAR_W'(digs[i]), err: 1'b0,
                                  end_mark: 1'b0});
      end
      expected_text.push_back('{code: CHAR_NUL, err: 1'b0, end_mark: 1'b1});
    end
  endtask

  // predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    if (rst) begin
      expected_text.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (in_valid && !in_stall) predict_text(value, signed_mode, buffer_size);
      if (out_valid && !out_stall) begin
        got = '{code: character, err: overflow_error, end_mark: last};
        if (expected_text.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output, got char %h err %b last %b",
                   $realtime, got.code, got.err, got.end_mark);
        end else begin
          want = expected_text.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: output mismatch, expected char %h err %b last %b, got char %h err %b last %b",
                     $realtime, want.code, want.err, want.end_mark,
                     got.code, got.err, got.end_mark);
          end
        end
      end
      pending = expected_text.size();
    end
  end

endmodule

/* sim/binary_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
  import bda_pkg::*;

  localparam int RANDOM_ITEMS = 360;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] value;
  logic               signed_mode;
  logic [BUF_W-1:0]   buffer_size;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  character;
  logic               overflow_error;
  logic               last;
  int                 fail_count;
  int                 pending;
  int                 cycle_count;

  binary_to_decimal_ascii dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .value          (value),
    .signed_mode    (signed_mode),
    .buffer_size    (buffer_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .character      (character),
    .overflow_error (overflow_error),
    .last           (last)
  );

  decimal_text_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .value          (value),
    .signed_mode    (signed_mode),
    .buffer_size    (buffer_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .character      (character),
    .overflow_error (overflow_error),
    .last           (last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one number and hold it until the transfer
  task automatic send_number(input logic [VALUE_W-1:0] v, input logic sm,
                             input logic [BUF_W-1:0] room);
    @(negedge clk);
    in_valid    <= 1'b1;
    value       <= v;
    signed_mode <= sm;
    buffer_size <= room;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid for a number of cycles, nothing when zero
  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // let everything in flight come out
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: bursts of different stall behaviour, including long holds
  initial begin
    int burst;
    int mode;
    int hold;
    out_stall = 1'b0;
    hold      = 0;
    forever begin
      burst = $urandom_range(20, 80);
      mode  = $urandom_range(0, 3);
      repeat (burst) begin
        @(negedge clk);
        if (hold > 0) begin
          hold--;
          out_stall <= 1'b1;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: begin
              if ($urandom_range(0, 15) == 0) begin
                hold = $urandom_range(5, 30);
                out_stall <= 1'b1;
              end else begin
                out_stall <= 1'b0;
              end
            end
          endcase
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p10;
    logic               sm;
    int                 kind;
    int                 need;
    int                 room;
    string              text;

    rst         = 1'b1;
    in_valid    = 1'b0;
    value       = '0;
    signed_mode = 1'b0;
    buffer_size = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, buffer edges, widest values, signed extremes
    send_number(64'd0, 1'b0, 8'd2);
    send_number(64'd0, 1'b0, 8'd1);
    send_number(64'd0, 1'b0, 8'd0);
    send_number('1, 1'b0, 8'd21);
    idle_for(pick_gap());
    send_number('1, 1'b0, 8'd20);
    send_number('1, 1'b0, 8'd255);
    send_number(64'd10000000000000000000, 1'b0, 8'd21);
    send_number(64'd9999999999999999999, 1'b0, 8'd20);
    send_number(64'd9, 1'b0, 8'd2);
    send_number(64'd10, 1'b0, 8'd2);
    idle_for(pick_gap());
    send_number(64'hdead_beef_8000_0000, 1'b1, 8'd12);
    send_number(64'hdead_beef_8000_0000, 1'b1, 8'd11);
    send_number(64'hffff_ffff_7fff_ffff, 1'b1, 8'd11);
    send_number(64'h0000_0000_ffff_ffff, 1'b1, 8'd3);
    send_number(64'h1234_5678_ffff_ffff, 1'b1, 8'd2);
    send_number(64'hffff_ffff_0000_0000, 1'b1, 8'd2);
    send_number(64'h0000_0000_8000_0000, 1'b0, 8'd11);
    send_number(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 8'd22);
    send_number(64'h5555_5555_5555_5555, 1'b0, 8'd128);
    send_number(64'h0000_0000_0000_0001, 1'b1, 8'd1);
    idle_for(1);
    wait_drained();

    // random numbers, sizes mostly around the fit boundary
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      v    = {$urandom, $urandom};
      case (kind)
        0, 1, 2, 3: v = v >> $urandom_range(0, 63);
        4: begin
          p10 = 64'd1;
          repeat ($urandom_range(0, 19)) p10 = p10 * 64'd10;
          v = p10 + 64'($urandom_range(0, 2)) - 64'd1;
        end
        5: ;
        6: v = 64'($urandom_range(0, 99));
        default: begin
          case ($urandom_range(0, 5))
            0: v[HALF_W-1:0] = 32'h8000_0000;
            1: v[HALF_W-1:0] = 32'h7fff_ffff;
            2: v[HALF_W-1:0] = 32'hffff_ffff;
            3: v[HALF_W-1:0] = v[HALF_W-1:0] >> $urandom_range(0, 31);
            default: ;
          endcase
        end
      endcase
      sm = (kind >= 7) ? 1'b1 : ($urandom_range(0, 4) == 0);

      text = sm ? $sformatf("%0d", $signed(v[HALF_W-1:0])) : $sformatf("%0d", v);
      need = text.len() + 1;
      case ($urandom_range(0, 9))
        7: room = $urandom_range(0, 255);
        8: room = $urandom_range(22, 255);
        9: room = $urandom_range(0, 3);
        default: begin
          room = need + $urandom_range(0, 3) - 2;
          if (room < 0) room = 0;
        end
      endcase

      send_number(v, sm, BUF_W'(room));

      // a calm stretch with back-to-back items, and a full drain now and then
      if (i % 90 == 89) begin
        idle_for(1);
        wait_drained();
      end else if (i % 64 < 16) begin
        idle_for(0);
      end else begin
        idle_for(pick_gap());
      end
    end
    idle_for(1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bda_pkg.sv
rtl/core/bda_cell.sv
rtl/core/bda_conv.sv
rtl/core/binary_to_decimal_ascii.sv
sim/decimal_text_checker.sv
sim/binary_to_decimal_ascii_tb.sv
